// ----- rtl/muv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muv_pkg
// Shared widths, constants, register codes and the stage-to-stage payload
// type of the minmod upwind velocity update pipeline.
// ----------------------------------------------------------------------------
package muv_pkg;

  // fixed point format
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned DATA_W     = 32;

  // configuration and index widths
  localparam int unsigned DT_W       = 31;
  localparam int unsigned VP_W       = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 31;

  // datapath widths
  localparam int unsigned DIFF_W  = DATA_W + 1;           // neighbor difference
  localparam int unsigned MM_W    = DATA_W + 3;           // scaled minmod operand
  localparam int unsigned SLOPE_W = DATA_W + 1;           // doubled limited slope
  localparam int unsigned W_W     = DATA_W + 1;           // upwind weight
  localparam int unsigned DS_W    = DATA_W + 2;           // slope difference
  localparam int unsigned CPROD_W = 2 * DATA_W;           // accel * dt product
  localparam int unsigned WP_W    = W_W + DS_W;           // weight * slope diff
  localparam int unsigned RND_W   = WP_W - FRAC_BITS - 2; // rounded correction
  localparam int unsigned B_W     = RND_W + 1;            // bracket term
  localparam int unsigned MB_HI_W = B_W - DATA_W;         // upper partial operand
  localparam int unsigned FULL_W  = B_W + DATA_W;         // full increment product

  // reset values of the configuration registers
  localparam logic [DT_W-1:0] DT_RESET = DT_W'(64'd1 << FRAC_BITS);
  localparam logic [VP_W-1:0] VP_RESET = VP_W'(32);

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DT_OVER_HV = CFG_IDX_W'(0),
    CFG_VEL_POINTS = CFG_IDX_W'(1)
  } muv_cfg_e;

  // payload handed from the stencil front end to the product back end
  typedef struct packed {
    logic              pos;     // cfl strictly positive
    logic              over;    // |cfl| above one
    logic [DATA_W-1:0] cfl;     // clipped cfl, signed
    logic [W_W-1:0]    w;       // upwind weight, signed
    logic [DS_W-1:0]   dslope;  // slope difference, signed
    logic [DIFF_W-1:0] base;    // first order difference, signed
  } muv_mid_t;

endpackage

// ----- rtl/muv_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muv_in_if
// Request channel: acceleration, five stencil values and the velocity index.
// ----------------------------------------------------------------------------
interface muv_in_if import muv_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] accel;
  logic signed [DATA_W-1:0] f_down2;
  logic signed [DATA_W-1:0] f_down1;
  logic signed [DATA_W-1:0] f_center;
  logic signed [DATA_W-1:0] f_up1;
  logic signed [DATA_W-1:0] f_up2;
  logic [IDX_W-1:0]         vel_index;

  modport source (
    output valid, accel, f_down2, f_down1, f_center, f_up1, f_up2, vel_index,
    input  ready
  );

  modport sink (
    input  valid, accel, f_down2, f_down1, f_center, f_up1, f_up2, vel_index,
    output ready
  );

endinterface

// ----- rtl/muv_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muv_out_if
// Result channel: saturated increment with its instability and clip flags.
// ----------------------------------------------------------------------------
interface muv_out_if import muv_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] f_update;
  logic                     cfl_over_one;
  logic                     saturated;

  modport source (
    output valid, f_update, cfl_over_one, saturated,
    input  ready
  );

  modport sink (
    input  valid, f_update, cfl_over_one, saturated,
    output ready
  );

endinterface

// ----- rtl/muv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muv_front
// Three stage front end: edge masking and cfl product, cfl rounding with
// minmod slopes, then upwind branch selection and weight forming.
// ----------------------------------------------------------------------------
module muv_front import muv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [DT_W-1:0]          dt_over_hv_i,
  input  logic [VP_W-1:0]          vel_points_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] accel_i,
  input  logic signed [DATA_W-1:0] f_down2_i,
  input  logic signed [DATA_W-1:0] f_down1_i,
  input  logic signed [DATA_W-1:0] f_center_i,
  input  logic signed [DATA_W-1:0] f_up1_i,
  input  logic signed [DATA_W-1:0] f_up2_i,
  input  logic [IDX_W-1:0]         vel_index_i,
  output logic                     mid_valid_o,
  input  logic                     mid_ready_i,
  output muv_mid_t                 mid_o
);

  localparam int unsigned NStage = 3;
  localparam int unsigned HiW    = CPROD_W - FRAC_BITS - DATA_W + 1;

  localparam logic signed [CPROD_W-1:0] CflHalf    = CPROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [DATA_W-1:0]  CflMax     = DATA_W'((64'd1 << (DATA_W - 1)) - 1);
  localparam logic signed [DATA_W-1:0]  CflMin     = DATA_W'(64'd1 << (DATA_W - 1));
  localparam logic signed [DATA_W-1:0]  OneD       = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0]  NegOneD    = -OneD;
  localparam logic signed [W_W-1:0]     OneW       = W_W'(64'd1 << FRAC_BITS);

  // doubled minmod slope of three consecutive points
  function automatic logic signed [SLOPE_W-1:0] slope2x(
    input logic signed [DATA_W-1:0] p,
    input logic signed [DATA_W-1:0] q,
    input logic signed [DATA_W-1:0] r
  );
    logic signed [DIFF_W-1:0] dqp;
    logic signed [DIFF_W-1:0] drq;
    logic signed [DIFF_W-1:0] drp;
    logic signed [MM_W-1:0]   a;
    logic signed [MM_W-1:0]   b;
    logic signed [MM_W-1:0]   c;
    logic signed [MM_W-1:0]   m;
    dqp = DIFF_W'(q) - DIFF_W'(p);
    drq = DIFF_W'(r) - DIFF_W'(q);
    drp = DIFF_W'(r) - DIFF_W'(p);
    a   = $signed({dqp, 2'b00});
    b   = $signed({drq, 2'b00});
    c   = MM_W'(drp);
    m   = '0;
    if (a > 0 && b > 0 && c > 0) begin
      m = (a < b) ? a : b;
      m = (m < c) ? m : c;
    end else if (a < 0 && b < 0 && c < 0) begin
      m = (a > b) ? a : b;
      m = (m > c) ? m : c;
    end
    return m[SLOPE_W-1:0];
  endfunction

  // stage enables, a stage moves when empty or when its successor moves
  logic [NStage-1:0] v_q;
  logic [NStage-1:0] en;

  always_comb begin
    en[NStage-1] = !v_q[NStage-1] || mid_ready_i;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign mid_valid_o = v_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: grid edge masking and cfl product
  logic signed [CPROD_W-1:0] cprod_d, cprod_q;
  logic signed [DATA_W-1:0]  d2_d, d1_d, c_d, u1_d, u2_d;
  logic signed [DATA_W-1:0]  d2_q, d1_q, c_q, u1_q, u2_q;
  logic [VP_W-1:0]           idx_ext;

  always_comb begin
    idx_ext = VP_W'(vel_index_i);
    cprod_d = $signed(accel_i) * $signed({1'b0, dt_over_hv_i});
    d2_d    = (vel_index_i < IDX_W'(2)) ? '0 : f_down2_i;
    d1_d    = (vel_index_i < IDX_W'(1)) ? '0 : f_down1_i;
    c_d     = f_center_i;
    u1_d    = (idx_ext + VP_W'(1) >= vel_points_i) ? '0 : f_up1_i;
    u2_d    = (idx_ext + VP_W'(2) >= vel_points_i) ? '0 : f_up2_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cprod_q <= cprod_d;
      d2_q    <= d2_d;
      d1_q    <= d1_d;
      c_q     <= c_d;
      u1_q    <= u1_d;
      u2_q    <= u2_d;
    end
  end

  // stage 2: cfl rounding and clipping, limited slopes
  logic signed [CPROD_W-1:0] csum;
  logic [HiW-1:0]            chi;
  logic signed [DATA_W-1:0]  cfl_d, cfl_q;
  logic                      over_d, over_q;
  logic signed [SLOPE_W-1:0] sa_d, sb_d, sc_d, sa_q, sb_q, sc_q;
  logic signed [DIFF_W-1:0]  dlo_d, dhi_d, dlo_q, dhi_q;

  always_comb begin
    csum = cprod_q + (cprod_q[CPROD_W-1] ? (CflHalf - CPROD_W'(1)) : CflHalf);
    chi  = csum[CPROD_W-1:FRAC_BITS+DATA_W-1];
    if (&chi || ~|chi) begin
      cfl_d = $signed(csum[FRAC_BITS+DATA_W-1:FRAC_BITS]);
    end else begin
      cfl_d = csum[CPROD_W-1] ? CflMin : CflMax;
    end
    over_d = (cfl_d > OneD) || (cfl_d < NegOneD);
    sa_d   = slope2x(d2_q, d1_q, c_q);
    sb_d   = slope2x(d1_q, c_q, u1_q);
    sc_d   = slope2x(c_q, u1_q, u2_q);
    dlo_d  = DIFF_W'(c_q) - DIFF_W'(d1_q);
    dhi_d  = DIFF_W'(u1_q) - DIFF_W'(c_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cfl_q  <= cfl_d;
      over_q <= over_d;
      sa_q   <= sa_d;
      sb_q   <= sb_d;
      sc_q   <= sc_d;
      dlo_q  <= dlo_d;
      dhi_q  <= dhi_d;
    end
  end

  // stage 3: upwind branch, weight and slope difference
  logic                     pos;
  logic signed [W_W-1:0]    cfl_w;
  muv_mid_t                 mid_d, mid_q;

  always_comb begin
    pos          = !cfl_q[DATA_W-1] && (cfl_q != '0);
    cfl_w        = W_W'(cfl_q);
    mid_d.pos    = pos;
    mid_d.over   = over_q;
    mid_d.cfl    = cfl_q;
    mid_d.w      = pos ? (OneW - cfl_w) : (OneW + cfl_w);
    mid_d.dslope = pos ? (DS_W'(sb_q) - DS_W'(sa_q)) : (DS_W'(sc_q) - DS_W'(sb_q));
    mid_d.base   = pos ? dlo_q : dhi_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

// ----- rtl/muv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muv_back
// Five stage back end: weight product, rounded bracket term, magnitudes,
// split increment product and final rounding with saturation.
// ----------------------------------------------------------------------------
module muv_back import muv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     mid_valid_i,
  output logic                     mid_ready_o,
  input  muv_mid_t                 mid_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] f_update_o,
  output logic                     cfl_over_one_o,
  output logic                     saturated_o
);

  localparam int unsigned NStage = 5;
  localparam int unsigned QW     = FULL_W - FRAC_BITS;

  localparam logic signed [WP_W-1:0] RndHalf = WP_W'(128'd1 << (FRAC_BITS + 1));
  localparam logic [FULL_W-1:0]      IncHalf = FULL_W'(128'd1 << (FRAC_BITS - 1));
  localparam logic [QW-1:0]          LimPos  = QW'((128'd1 << (DATA_W - 1)) - 1);
  localparam logic [QW-1:0]          LimNeg  = QW'(128'd1 << (DATA_W - 1));

  // stage enables, a stage moves when empty or when its successor moves
  logic [NStage-1:0] v_q;
  logic [NStage-1:0] en;

  always_comb begin
    en[NStage-1] = !v_q[NStage-1] || out_ready_i;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign mid_ready_o = en[0];
  assign out_valid_o = v_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= mid_valid_i;
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: weight times slope difference
  logic signed [WP_W-1:0]   wp_d, wp_q;
  logic                     pos1_q, over1_q;
  logic signed [DATA_W-1:0] cfl1_q;
  logic signed [DIFF_W-1:0] base1_q;

  assign wp_d = $signed(mid_i.w) * $signed(mid_i.dslope);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      wp_q    <= wp_d;
      pos1_q  <= mid_i.pos;
      over1_q <= mid_i.over;
      cfl1_q  <= $signed(mid_i.cfl);
      base1_q <= $signed(mid_i.base);
    end
  end

  // stage 2: round the correction and form the bracket term
  logic signed [WP_W-1:0]   wsum;
  logic signed [RND_W-1:0]  corr;
  logic signed [B_W-1:0]    b_d, b_q;
  logic                     over2_q;
  logic signed [DATA_W-1:0] cfl2_q;

  always_comb begin
    wsum = wp_q + (wp_q[WP_W-1] ? (RndHalf - WP_W'(1)) : RndHalf);
    corr = $signed(wsum[WP_W-1:FRAC_BITS+2]);
    b_d  = pos1_q ? (B_W'(base1_q) + B_W'(corr)) : (B_W'(base1_q) - B_W'(corr));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_q     <= b_d;
      cfl2_q  <= cfl1_q;
      over2_q <= over1_q;
    end
  end

  // stage 3: magnitudes and sign of the increment
  logic [DATA_W-1:0] ma_d, ma_q;
  logic [B_W-1:0]    mb_d, mb_q;
  logic              neg_d, neg3_q, over3_q;
  logic              b_pos, cfl_pos;

  always_comb begin
    ma_d    = cfl2_q[DATA_W-1] ? (~cfl2_q + DATA_W'(1)) : cfl2_q;
    mb_d    = b_q[B_W-1] ? (~b_q + B_W'(1)) : b_q;
    b_pos   = !b_q[B_W-1] && (b_q != '0);
    cfl_pos = !cfl2_q[DATA_W-1] && (cfl2_q != '0);
    neg_d   = (cfl_pos && b_pos) || (cfl2_q[DATA_W-1] && b_q[B_W-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ma_q    <= ma_d;
      mb_q    <= mb_d;
      neg3_q  <= neg_d;
      over3_q <= over2_q;
    end
  end

  // stage 4: split magnitude product, low and high partials
  logic [2*DATA_W-1:0]       plo_d, plo_q;
  logic [DATA_W+MB_HI_W-1:0] phi_d, phi_q;
  logic                      neg4_q, over4_q;

  assign plo_d = ma_q * mb_q[DATA_W-1:0];
  assign phi_d = ma_q * mb_q[B_W-1:DATA_W];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      neg4_q  <= neg3_q;
      over4_q <= over3_q;
    end
  end

  // stage 5: combine partials, round, saturate and apply sign
  logic [FULL_W-1:0]        full;
  logic [QW-1:0]            qmag;
  logic [QW-1:0]            lim;
  logic [DATA_W-1:0]        qsat;
  logic                     sat_d, sat_q, over_q;
  logic signed [DATA_W-1:0] inc_d, f_update_q;

  always_comb begin
    full  = {phi_q, {DATA_W{1'b0}}} + FULL_W'(plo_q) + IncHalf;
    qmag  = full[FULL_W-1:FRAC_BITS];
    lim   = neg4_q ? LimNeg : LimPos;
    sat_d = qmag > lim;
    qsat  = sat_d ? lim[DATA_W-1:0] : qmag[DATA_W-1:0];
    inc_d = neg4_q ? $signed(~qsat + DATA_W'(1)) : $signed(qsat);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      f_update_q <= inc_d;
      sat_q      <= sat_d;
      over_q     <= over4_q;
    end
  end

  assign f_update_o     = f_update_q;
  assign cfl_over_one_o = over_q;
  assign saturated_o    = sat_q;

  // a free result side never holds back the front end
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> mid_ready_o)
    else $error("back end stalls with result side ready");

  // a clipped increment sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NStage-1] && sat_q) |->
      (f_update_q == $signed(LimPos[DATA_W-1:0]) ||
       f_update_q == $signed(LimNeg[DATA_W-1:0])))
    else $error("saturated increment off the range limit");

  // a zero product, as from zero cfl, gives a zero, unclipped increment
  a_zero_cfl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && en[4] && plo_q == '0 && phi_q == '0) |=> (f_update_q == '0 && !sat_q))
    else $error("zero cfl gave a nonzero increment");

  // a stalled stage in front of the result stage keeps its item
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NStage-2] && !en[NStage-2]) |=> v_q[NStage-2])
    else $error("stalled item dropped before the output register");

endmodule

// ----- rtl/minmod_upwind_velocity_update_top.sv -----
`timescale 1ns / 1ps
// eight register stages, three in the front end and five in the back end
// throughput: one request per cycle, every stage advances while the result side is ready
// a stalled result side freezes only the stages that are full behind it
// reset: pipeline emptied, dt_over_hv set to 1.0, vel_points set to 32
// no clearing pass, requests are taken in the first cycle after reset
// ----------------------------------------------------------------------------
// minmod_upwind_velocity_update_top
// Second order minmod-limited upwind increment along the velocity axis for
// one grid point per request, with configuration registers.
// ----------------------------------------------------------------------------
module minmod_upwind_velocity_update_top import muv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  muv_in_if.sink                req,
  muv_out_if.source             res
);

  // configuration registers
  logic [DT_W-1:0] dt_over_hv_q;
  logic [VP_W-1:0] vel_points_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_over_hv_q <= DT_RESET;
      vel_points_q <= VP_RESET;
    end else if (cfg_we_i) begin
      case (muv_cfg_e'(cfg_idx_i))
        CFG_DT_OVER_HV: dt_over_hv_q <= cfg_data_i[DT_W-1:0];
        CFG_VEL_POINTS: vel_points_q <= cfg_data_i[VP_W-1:0];
        default: ;
      endcase
    end
  end

  // stencil front end
  logic     mid_valid;
  logic     mid_ready;
  muv_mid_t mid;

  muv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dt_over_hv_i (dt_over_hv_q),
    .vel_points_i (vel_points_q),
    .in_valid_i   (req.valid),
    .in_ready_o   (req.ready),
    .accel_i      (req.accel),
    .f_down2_i    (req.f_down2),
    .f_down1_i    (req.f_down1),
    .f_center_i   (req.f_center),
    .f_up1_i      (req.f_up1),
    .f_up2_i      (req.f_up2),
    .vel_index_i  (req.vel_index),
    .mid_valid_o  (mid_valid),
    .mid_ready_i  (mid_ready),
    .mid_o        (mid)
  );

  // product and saturation back end
  muv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mid_valid_i    (mid_valid),
    .mid_ready_o    (mid_ready),
    .mid_i          (mid),
    .out_valid_o    (res.valid),
    .out_ready_i    (res.ready),
    .f_update_o     (res.f_update),
    .cfl_over_one_o (res.cfl_over_one),
    .saturated_o    (res.saturated)
  );

endmodule

// ----- tb/muv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muv_checker
// Watches the request, result and configuration ports of the minmod upwind
// velocity update. It keeps a shadow of both registers, predicts the
// increment and its flags for every accepted request, and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module muv_checker import muv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  muv_in_if                     req,
  muv_out_if                    res,
  output int unsigned           mismatch_cnt_o,
  output int unsigned           pending_o
);

  // wide signed arithmetic keeps every intermediate exact
  localparam int unsigned WIDE = 128;
  localparam logic signed [WIDE-1:0] ONE_W       = 1;
  localparam logic signed [WIDE-1:0] S32_MAX     = 128'sh7FFF_FFFF;
  localparam logic signed [WIDE-1:0] S32_NEG_LIM = 128'sh8000_0000;
  localparam logic signed [WIDE-1:0] S32_MIN     = -S32_NEG_LIM;

  typedef struct {
    logic signed [DATA_W-1:0] f_update;
    logic                     over;
    logic                     sat;
  } incr_t;

  incr_t             incr_q[$];
  logic [DT_W-1:0]   dt_q;
  logic [VP_W-1:0]   vp_q;
  int unsigned       mismatch_cnt = 0;
  int unsigned       res_cnt = 0;

  // v / 2^s rounded half away from zero
  function automatic logic signed [WIDE-1:0] round_half_away(
    input logic signed [WIDE-1:0] v,
    input int unsigned            s
  );
    logic signed [WIDE-1:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (ONE_W <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // smallest magnitude when all three agree in sign, else zero
  function automatic logic signed [WIDE-1:0] minmod3(
    input logic signed [WIDE-1:0] x,
    input logic signed [WIDE-1:0] y,
    input logic signed [WIDE-1:0] z
  );
    logic signed [WIDE-1:0] m;
    m = '0;
    if (x > 0 && y > 0 && z > 0) begin
      m = x;
      if (y < m) m = y;
      if (z < m) m = z;
    end else if (x < 0 && y < 0 && z < 0) begin
      m = x;
      if (y > m) m = y;
      if (z > m) m = z;
    end
    return m;
  endfunction

  // limited slope in grid units, doubled so it stays integer
  function automatic logic signed [WIDE-1:0] doubled_slope(
    input logic signed [WIDE-1:0] p,
    input logic signed [WIDE-1:0] q,
    input logic signed [WIDE-1:0] r
  );
    return minmod3(4 * (q - p), 4 * (r - q), r - p);
  endfunction

  // upwind increment for one stencil under the given register values
  function automatic incr_t upwind_increment(
    input logic signed [DATA_W-1:0] accel,
    input logic signed [DATA_W-1:0] fd2,
    input logic signed [DATA_W-1:0] fd1,
    input logic signed [DATA_W-1:0] fc,
    input logic signed [DATA_W-1:0] fu1,
    input logic signed [DATA_W-1:0] fu2,
    input logic [IDX_W-1:0]         idx,
    input logic [DT_W-1:0]          dt,
    input logic [VP_W-1:0]          vp
  );
    logic signed [WIDE-1:0] d2, d1, c, u1, u2, acc_w, dt_w;
    logic signed [WIDE-1:0] cfl, unit, w, b, ma, mb, q, lim, inc;
    bit                     neg;
    incr_t                  r;
    d2    = fd2;
    d1    = fd1;
    c     = fc;
    u1    = fu1;
    u2    = fu2;
    acc_w = accel;
    dt_w  = {1'b0, dt};
    unit  = ONE_W <<< FRAC_BITS;

    // neighbours off the grid read as zero, center is kept as given
    if (idx < 2) d2 = '0;
    if (idx < 1) d1 = '0;
    if (idx + 1 >= vp) u1 = '0;
    if (idx + 2 >= vp) u2 = '0;

    // courant number, clipped to 32 bits
    cfl = round_half_away(acc_w * dt_w, FRAC_BITS);
    if (cfl > S32_MAX) cfl = S32_MAX;
    if (cfl < S32_MIN) cfl = S32_MIN;
    r.over = (cfl > unit) || (cfl < -unit);

    // second order upwind bracket, zero cfl takes the lower branch
    if (cfl > 0) begin
      w = unit - cfl;
      b = (c - d1) + round_half_away(
            w * (doubled_slope(d1, c, u1) - doubled_slope(d2, d1, c)), FRAC_BITS + 2);
    end else begin
      w = unit + cfl;
      b = (u1 - c) - round_half_away(
            w * (doubled_slope(c, u1, u2) - doubled_slope(d1, c, u1)), FRAC_BITS + 2);
    end

    // -cfl * b rescaled, then saturated to 32 bits
    neg = (cfl > 0 && b > 0) || (cfl < 0 && b < 0);
    ma  = (cfl < 0) ? -cfl : cfl;
    mb  = (b < 0) ? -b : b;
    q   = (ma * mb + (ONE_W <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    lim = neg ? S32_NEG_LIM : S32_MAX;
    r.sat = q > lim;
    if (r.sat) q = lim;
    inc = neg ? -q : q;
    r.f_update = inc[DATA_W-1:0];
    return r;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(
    input string             what,
    input logic [DATA_W-1:0] got,
    input logic [DATA_W-1:0] want
  );
    $display("muv_checker: result %0d: %s got %h expected %h", res_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // results are checked before the new request of the same edge is queued
  always @(posedge clk_i or negedge rst_ni) begin
    incr_t want;
    if (!rst_ni) begin
      incr_q.delete();
      dt_q           = DT_RESET;
      vp_q           = VP_RESET;
      pending_o      <= 0;
      mismatch_cnt_o <= mismatch_cnt;
    end else begin
      if (res.valid && res.ready) begin
        if (incr_q.size() == 0) begin
          report_mismatch("result with no request", res.f_update, '0);
        end else begin
          want = incr_q.pop_front();
          if (res.f_update !== want.f_update)
            report_mismatch("f_update", res.f_update, want.f_update);
          if (res.cfl_over_one !== want.over)
            report_mismatch("cfl_over_one", DATA_W'(res.cfl_over_one), DATA_W'(want.over));
          if (res.saturated !== want.sat)
            report_mismatch("saturated", DATA_W'(res.saturated), DATA_W'(want.sat));
        end
        res_cnt++;
      end

      if (req.valid && req.ready)
        incr_q.push_back(upwind_increment(req.accel, req.f_down2, req.f_down1,
                                          req.f_center, req.f_up1, req.f_up2,
                                          req.vel_index, dt_q, vp_q));

      // register shadow
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DT_OVER_HV: dt_q = cfg_data_i[DT_W-1:0];
          CFG_VEL_POINTS: vp_q = cfg_data_i[VP_W-1:0];
          default: ;
        endcase
      end

      pending_o      <= incr_q.size();
      mismatch_cnt_o <= mismatch_cnt;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the minmod upwind velocity update. A directed
// set covers zero, unit and clipped cfl, grid edges, points beyond the grid
// and saturation; random stencils follow under several register settings,
// with random idling on both channels. Checking sits in muv_checker.
// ----------------------------------------------------------------------------
module tb import muv_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned MAX_WAIT    = 17;

  localparam logic signed [DATA_W-1:0] ONE_Q  = 32'sh0100_0000;
  localparam logic signed [DATA_W-1:0] HALF_Q = 32'sh0080_0000;
  localparam logic signed [DATA_W-1:0] MAXV   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MINV   = 32'sh8000_0000;
  localparam logic [DT_W-1:0]          DT_MAX = 31'h7FFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] accel, d2, d1, c, u1, u2;
    logic [IDX_W-1:0]         idx;
  } stencil_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           mismatch_cnt;
  int unsigned           pending;
  int unsigned           cycle_cnt = 0;
  int unsigned           tx_run = 0;
  bit                    calm_tx = 1'b0;
  logic [VP_W-1:0]       vp_cur;

  muv_in_if  req_if ();
  muv_out_if res_if ();

  minmod_upwind_velocity_update_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .res        (res_if)
  );

  muv_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req            (req_if),
    .res            (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // idle cycles before one transfer, none inside a calm stretch
  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic stencil_t make_stencil(
    input logic signed [DATA_W-1:0] accel,
    input logic signed [DATA_W-1:0] d2,
    input logic signed [DATA_W-1:0] d1,
    input logic signed [DATA_W-1:0] c,
    input logic signed [DATA_W-1:0] u1,
    input logic signed [DATA_W-1:0] u2,
    input int unsigned              idx
  );
    stencil_t s;
    s.accel = accel;
    s.d2    = d2;
    s.d1    = d1;
    s.c     = c;
    s.u1    = u1;
    s.u2    = u2;
    s.idx   = IDX_W'(idx);
    return s;
  endfunction

  // rising line 1.0 .. 5.0
  function automatic stencil_t ramp_at(input logic signed [DATA_W-1:0] accel,
                                       input int unsigned idx);
    return make_stencil(accel, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q, idx);
  endfunction

  // mostly smooth stencils so the limiter sees agreeing slopes
  function automatic stencil_t rand_stencil(input logic [VP_W-1:0] vp);
    stencil_t                 s;
    logic signed [DATA_W-1:0] f [5];
    logic signed [DATA_W-1:0] base, step;
    int unsigned              vpn, kind, pick;
    vpn  = 32'(vp);
    base = $urandom;
    step = $signed($urandom) >>> $urandom_range(4, 28);
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 5; k++) begin
      case (kind)
        0: f[k] = $urandom;
        7: f[k] = base + (k - 2) * (k - 2) * step;
        8: f[k] = base;
        9: begin
          case ($urandom_range(0, 4))
            0: f[k] = MAXV;
            1: f[k] = MINV;
            2: f[k] = '0;
            3: f[k] = 1;
            default: f[k] = -1;
          endcase
        end
        default: f[k] = base + k * step + ($signed($urandom) >>> $urandom_range(8, 31));
      endcase
    end
    s.d2 = f[0];
    s.d1 = f[1];
    s.c  = f[2];
    s.u1 = f[3];
    s.u2 = f[4];

    // acceleration over a wide spread of magnitudes
    if ($urandom_range(0, 9) == 0) s.accel = $urandom;
    else s.accel = $signed($urandom) >>> $urandom_range(0, 31);

    // index: mostly inside, often at an edge, sometimes beyond the grid
    pick = $urandom_range(0, 19);
    if (pick == 0) s.idx = IDX_W'($urandom);
    else if (pick == 1 && vpn < 1024) s.idx = IDX_W'($urandom_range(vpn, 1023));
    else if (pick < 6) begin
      case (pick)
        2: s.idx = '0;
        3: s.idx = IDX_W'(1);
        4: s.idx = IDX_W'(vpn - 2);
        default: s.idx = IDX_W'(vpn - 1);
      endcase
    end else s.idx = IDX_W'($urandom_range(0, vpn - 1));
    return s;
  endfunction

  // one request, valid held until accepted
  task automatic send_stencil(input stencil_t s);
    int unsigned gap;
    if (tx_run == 0) begin
      calm_tx = ($urandom_range(0, 3) == 0);
      tx_run  = $urandom_range(20, 80);
    end
    tx_run--;
    gap = draw_wait(calm_tx);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.accel     <= s.accel;
    req_if.f_down2   <= s.d2;
    req_if.f_down1   <= s.d1;
    req_if.f_center  <= s.c;
    req_if.f_up1     <= s.u1;
    req_if.f_up2     <= s.u2;
    req_if.vel_index <= s.idx;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop sending and wait until every predicted result has been seen
  task automatic drain;
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input muv_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // result side, random back pressure
  initial begin
    int unsigned gap, run;
    bit          calm;
    res_if.ready = 1'b0;
    run  = 0;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (run == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        run  = $urandom_range(20, 80);
      end
      run--;
      gap = draw_wait(calm);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // request side and verdict
  initial begin
    logic [DT_W-1:0] dt_sel;
    logic [VP_W-1:0] vp_sel;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_DT_OVER_HV;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.accel       = '0;
    req_if.f_down2     = '0;
    req_if.f_down1     = '0;
    req_if.f_center    = '0;
    req_if.f_up1       = '0;
    req_if.f_up2       = '0;
    req_if.vel_index   = '0;
    vp_cur             = VP_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: cfl equals accel, 32 points
    send_stencil(make_stencil('0, '0, '0, '0, '0, '0, 0));
    send_stencil(ramp_at('0, 10));
    send_stencil(ramp_at(HALF_Q, 10));
    send_stencil(ramp_at(-HALF_Q, 10));
    send_stencil(make_stencil(ONE_Q, '0, ONE_Q, 4 * ONE_Q, 9 * ONE_Q, 16 * ONE_Q, 10));
    send_stencil(make_stencil(-ONE_Q, '0, ONE_Q, 4 * ONE_Q, 9 * ONE_Q, 16 * ONE_Q, 10));
    send_stencil(ramp_at(ONE_Q + 1, 10));
    // grid edges and points beyond the grid
    send_stencil(ramp_at(HALF_Q, 0));
    send_stencil(ramp_at(-HALF_Q, 1));
    send_stencil(ramp_at(HALF_Q, 30));
    send_stencil(ramp_at(-HALF_Q, 31));
    send_stencil(ramp_at(-HALF_Q, 32));
    send_stencil(ramp_at(HALF_Q, 1023));
    // field extremes and saturation
    send_stencil(make_stencil(MAXV, MAXV, MINV, MAXV, MAXV, MAXV, 10));
    send_stencil(make_stencil(MINV, MAXV, MINV, MAXV, MINV, MAXV, 10));
    send_stencil(make_stencil(HALF_Q, MAXV, MAXV, MAXV, MAXV, MAXV, 5));
    send_stencil(make_stencil(-HALF_Q, MINV, MINV, MINV, MINV, MINV, 5));
    send_stencil(make_stencil($urandom, MINV, MAXV, MINV, MAXV, MINV, 15));
    drain();

    // largest time step on the smallest grid: cfl clipping
    write_reg(CFG_DT_OVER_HV, DT_MAX);
    write_reg(CFG_VEL_POINTS, CFG_DATA_W'(3));
    vp_cur = VP_W'(3);
    send_stencil(ramp_at(MAXV, 1));
    send_stencil(ramp_at(MINV, 0));
    send_stencil(make_stencil(1, MAXV, MINV, MAXV, MAXV, MINV, 2));
    send_stencil(make_stencil(-1, MINV, MAXV, MINV, MINV, MAXV, 3));
    repeat (PHASE_ITEMS) send_stencil(rand_stencil(vp_cur));

    // further register settings, each after a full drain
    for (int p = 1; p < PHASES; p++) begin
      drain();
      case (p)
        1: begin dt_sel = '0;                                      vp_sel = VP_W'(1024); end
        2: begin dt_sel = 31'h0100_0000;                           vp_sel = VP_W'(1024); end
        3: begin dt_sel = DT_W'($urandom_range(0, 1 << 25));       vp_sel = VP_W'($urandom_range(3, 1024)); end
        4: begin dt_sel = 31'h0040_0000;                           vp_sel = VP_W'(4); end
        5: begin dt_sel = DT_W'($urandom);                         vp_sel = VP_W'($urandom_range(3, 1024)); end
        6: begin dt_sel = 31'h0100_0000 + DT_W'($urandom_range(0, 1 << 20)); vp_sel = VP_W'(5); end
        default: begin dt_sel = DT_W'($urandom_range(1 << 16, 1 << 24)); vp_sel = VP_RESET; end
      endcase
      write_reg(CFG_DT_OVER_HV, CFG_DATA_W'(dt_sel));
      write_reg(CFG_VEL_POINTS, CFG_DATA_W'(vp_sel));
      vp_cur = vp_sel;
      repeat (PHASE_ITEMS) send_stencil(rand_stencil(vp_cur));
    end

    // let the pipeline run dry, then judge
    drain();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
